// ----- rtl/assert_macros.svh -----
// Assertion helpers for the window layer compositor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked outside reset.
`define WLPC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define WLPC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WLPC_ASSERT(name, prop, msg)
`define WLPC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- rtl/wlpc_pkg.sv -----
`timescale 1ns / 1ps

package wlpc_pkg;

  typedef enum logic [2:0] {
    RGN_PASS    = 3'd0,
    RGN_SHADOW  = 3'd1,
    RGN_TITLE   = 3'd2,
    RGN_BUTTON  = 3'd3,
    RGN_CONTENT = 3'd4
  } region_t;

  typedef enum logic [2:0] {
    CFG_WIN_X      = 3'd0,
    CFG_WIN_Y      = 3'd1,
    CFG_WIN_WIDTH  = 3'd2,
    CFG_WIN_HEIGHT = 3'd3,
    CFG_FLAGS      = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_FLAT,
    MODE_BLEND
  } mode_t;

  localparam int FLAG_DECORATED = 0;
  localparam int FLAG_FOCUSED   = 1;
  localparam int FLAG_MINIMIZED = 2;
  localparam int FLAG_NO_SHADOW = 3;

  localparam int TITLE_H     = 24;
  localparam int SHADOW_W    = 8;
  localparam int BTN_SIZE    = 16;
  localparam int BTN_STEP    = 18;
  localparam int SHADOW_STEP = 20;
  // buttons: first one starts this far left of the content's right edge
  localparam int BTN_X_OFF   = BTN_SIZE * 3 + 6;
  // button rows start this far above the content top
  localparam int BTN_Y_OFF   = TITLE_H - (TITLE_H - BTN_SIZE) / 2;

  localparam logic [31:0] COL_TITLE_FOCUS = 32'hFF3C3C3C;
  localparam logic [31:0] COL_TITLE_IDLE  = 32'hFF5C5C5C;
  localparam logic [31:0] COL_CLOSE       = 32'hFFE81123;
  localparam logic [31:0] COL_MAXIMIZE    = 32'hFF00CC00;
  localparam logic [31:0] COL_MINIMIZE    = 32'hFFFFBB00;

  // shadow alpha for ring distance 1..8
  function automatic logic [7:0] shadow_alpha(input logic [3:0] ring_d);
    logic [7:0] a;
    case (ring_d)
      4'd1:    a = 8'((SHADOW_W - 1) * SHADOW_STEP);
      4'd2:    a = 8'((SHADOW_W - 2) * SHADOW_STEP);
      4'd3:    a = 8'((SHADOW_W - 3) * SHADOW_STEP);
      4'd4:    a = 8'((SHADOW_W - 4) * SHADOW_STEP);
      4'd5:    a = 8'((SHADOW_W - 5) * SHADOW_STEP);
      4'd6:    a = 8'((SHADOW_W - 6) * SHADOW_STEP);
      4'd7:    a = 8'((SHADOW_W - 7) * SHADOW_STEP);
      default: a = 8'd0;
    endcase
    return a;
  endfunction

  // floor(x / 255), exact for x <= 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/window_layer_pixel_compositor_top.sv -----
`timescale 1ns / 1ps
// One window layer of a display compositor. Each request carries a screen
// coordinate, the ARGB pixel already beneath it and the window's content
// pixel; the block returns the composited pixel and a region code
// (passthrough, shadow, title bar, button, content). Content is alpha-blended
// over the pixel beneath, decorations draw a title bar and three buttons
// above it, and an 8-pixel black shadow ring surrounds it. The block takes
// one pixel per clock, when the output is not back-pressured, through four
// register stages (input register, region decode, channel multiply,
// divide-by-255 into the output register); a result is offered once its
// request reaches the output register. Each stage holds independently, so
// bubbles close up under output back-pressure. Window registers may only be
// written while no pixel is in flight; derived edges update the next cycle.

`include "assert_macros.svh"

module window_layer_pixel_compositor_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // pixel_x, pixel_y, under_pixel, window_pixel (from bit 0), zero padded
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((2*COORD_BITS+64+7)/8)*8-1:0] s_axis_tdata,
  // out_pixel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,
  // region
  output logic [2:0]            m_axis_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import wlpc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SW = COORD_BITS + 2;

  // ---------------- configuration ----------------
  logic [CB-1:0] win_x;
  logic [CB-1:0] win_y;
  logic [CB-1:0] win_width;
  logic [CB-1:0] win_height;
  logic [3:0]    window_flags;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_x        <= '0;
      win_y        <= '0;
      win_width    <= '0;
      win_height   <= '0;
      window_flags <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIN_X:      win_x        <= cfg_data;
        CFG_WIN_Y:      win_y        <= cfg_data;
        CFG_WIN_WIDTH:  win_width    <= cfg_data;
        CFG_WIN_HEIGHT: win_height   <= cfg_data;
        CFG_FLAGS:      window_flags <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // window edges, precomputed once per cycle from the registers
  logic signed [SW-1:0] wx_s, wy_s, x1_c, y1_c;
  logic signed [SW-1:0] d_x0, d_x1, d_y0, d_y1;
  logic signed [SW-1:0] d_ty0, d_by0, d_by1;
  logic signed [SW-1:0] d_b0s, d_b0e, d_b1s, d_b1e, d_b2s, d_b2e;
  logic signed [SW-1:0] d_sx0, d_sx1, d_sy0, d_sy1;

  assign wx_s = {{2{win_x[CB-1]}}, win_x};
  assign wy_s = {{2{win_y[CB-1]}}, win_y};
  assign x1_c = wx_s + $signed({2'b00, win_width});
  assign y1_c = wy_s + $signed({2'b00, win_height});

  always_ff @(posedge clk) begin
    d_x0  <= wx_s;
    d_x1  <= x1_c;
    d_y0  <= wy_s;
    d_y1  <= y1_c;
    d_ty0 <= wy_s - SW'(TITLE_H);
    d_by0 <= wy_s - SW'(BTN_Y_OFF);
    d_by1 <= wy_s - SW'(BTN_Y_OFF - BTN_SIZE);
    d_b0s <= x1_c - SW'(BTN_X_OFF);
    d_b0e <= x1_c - SW'(BTN_X_OFF - BTN_SIZE);
    d_b1s <= x1_c - SW'(BTN_X_OFF - BTN_STEP);
    d_b1e <= x1_c - SW'(BTN_X_OFF - BTN_STEP - BTN_SIZE);
    d_b2s <= x1_c - SW'(BTN_X_OFF - 2 * BTN_STEP);
    d_b2e <= x1_c - SW'(BTN_X_OFF - 2 * BTN_STEP - BTN_SIZE);
    d_sx0 <= wx_s - SW'(SHADOW_W);
    d_sx1 <= x1_c + SW'(SHADOW_W);
    d_sy0 <= wy_s - SW'(SHADOW_W);
    d_sy1 <= y1_c + SW'(SHADOW_W);
  end

  // ---------------- stage flow control ----------------
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4 || m_axis_tready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign s_axis_tready = rdy1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_axis_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [CB-1:0] s1_px, s1_py;
  logic [31:0]   s1_under, s1_win;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_px    <= s_axis_tdata[CB-1:0];
      s1_py    <= s_axis_tdata[2*CB-1:CB];
      s1_under <= s_axis_tdata[2*CB+31:2*CB];
      s1_win   <= s_axis_tdata[2*CB+63:2*CB+32];
    end
  end

  // ---------------- region decode ----------------
  logic signed [SW-1:0] px_s, py_s;
  logic in_cx, in_cy, btn_row, on_b0, on_b1, on_b2, title_y, sh_x, sh_y;
  logic signed [SW-1:0] dx_lo, dx_hi, dy_lo, dy_hi;
  logic [3:0]  dx, dy, ring_d;
  logic [7:0]  sh_alpha;
  region_t     rgn_next;
  mode_t       mode_next;
  logic [31:0] fg_next;

  assign px_s = $signed({2'b00, s1_px});
  assign py_s = $signed({2'b00, s1_py});

  assign in_cx   = (px_s >= d_x0)  && (px_s < d_x1);
  assign in_cy   = (py_s >= d_y0)  && (py_s < d_y1);
  assign btn_row = (py_s >= d_by0) && (py_s < d_by1);
  assign on_b0   = (px_s >= d_b0s) && (px_s < d_b0e);
  assign on_b1   = (px_s >= d_b1s) && (px_s < d_b1e);
  assign on_b2   = (px_s >= d_b2s) && (px_s < d_b2e);
  assign title_y = (py_s >= d_ty0) && (py_s < d_y0);
  assign sh_x    = (px_s >= d_sx0) && (px_s < d_sx1);
  assign sh_y    = (py_s >= d_sy0) && (py_s < d_sy1);

  // ring distances; only the low bits matter inside the shadow box
  assign dx_lo = d_x0 - px_s;
  assign dx_hi = px_s - d_x1 + SW'(1);
  assign dy_lo = d_y0 - py_s;
  assign dy_hi = py_s - d_y1 + SW'(1);

  always_comb begin
    if (px_s < d_x0)       dx = dx_lo[3:0];
    else if (px_s >= d_x1) dx = dx_hi[3:0];
    else                   dx = 4'd0;
    if (py_s < d_y0)       dy = dy_lo[3:0];
    else if (py_s >= d_y1) dy = dy_hi[3:0];
    else                   dy = 4'd0;
    ring_d   = (dx > dy) ? dx : dy;
    sh_alpha = shadow_alpha(ring_d);
  end

  always_comb begin
    rgn_next  = RGN_PASS;
    mode_next = MODE_PASS;
    fg_next   = s1_win;
    if (window_flags[FLAG_MINIMIZED]) begin
      rgn_next  = RGN_PASS;
    end else if (in_cx && in_cy) begin
      rgn_next  = RGN_CONTENT;
      mode_next = MODE_BLEND;
    end else if (window_flags[FLAG_DECORATED] && btn_row && (on_b0 || on_b1 || on_b2)) begin
      rgn_next  = RGN_BUTTON;
      mode_next = MODE_FLAT;
      if (on_b0)      fg_next = COL_MINIMIZE;
      else if (on_b1) fg_next = COL_MAXIMIZE;
      else            fg_next = COL_CLOSE;
    end else if (window_flags[FLAG_DECORATED] && in_cx && title_y) begin
      rgn_next  = RGN_TITLE;
      mode_next = MODE_FLAT;
      fg_next   = window_flags[FLAG_FOCUSED] ? COL_TITLE_FOCUS : COL_TITLE_IDLE;
    end else if (!window_flags[FLAG_NO_SHADOW] && sh_x && sh_y) begin
      rgn_next  = RGN_SHADOW;
      mode_next = MODE_BLEND;
      fg_next   = {sh_alpha, 24'd0};
    end
  end

  // ---------------- stage 2 ----------------
  region_t     s2_rgn;
  mode_t       s2_mode;
  logic [31:0] s2_fg, s2_bg;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_rgn  <= rgn_next;
      s2_mode <= mode_next;
      s2_fg   <= fg_next;
      s2_bg   <= s1_under;
    end
  end

  // per-channel f*a + b*(255-a)
  logic [7:0]  s2_a, s2_ia;
  logic [15:0] sum_next [3];

  assign s2_a  = s2_fg[31:24];
  assign s2_ia = 8'd255 - s2_a;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = {8'd0, s2_fg[8*c +: 8]} * {8'd0, s2_a} +
                    {8'd0, s2_bg[8*c +: 8]} * {8'd0, s2_ia};
    end
  end

  // ---------------- stage 3 ----------------
  region_t     s3_rgn;
  mode_t       s3_mode;
  logic [31:0] s3_fg, s3_bg;
  logic [15:0] s3_sum [3];

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_rgn  <= s2_rgn;
      s3_mode <= s2_mode;
      s3_fg   <= s2_fg;
      s3_bg   <= s2_bg;
      s3_sum  <= sum_next;
    end
  end

  logic [31:0] pix_next;

  always_comb begin
    unique case (s3_mode)
      MODE_FLAT: pix_next = s3_fg;
      MODE_BLEND: begin
        if (s3_fg[31:24] == 8'hFF)      pix_next = s3_fg;
        else if (s3_fg[31:24] == 8'h00) pix_next = s3_bg;
        else pix_next = {8'hFF, div255(s3_sum[2]), div255(s3_sum[1]), div255(s3_sum[0])};
      end
      default: pix_next = s3_bg;
    endcase
  end

  // ---------------- stage 4: output register ----------------
  logic [31:0] out_pixel;
  region_t     out_region;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_pixel  <= pix_next;
      out_region <= s3_rgn;
    end
  end

  assign m_axis_tvalid = v4;
  assign m_axis_tdata  = out_pixel;
  assign m_axis_tuser  = out_region;

  // ---------------- assertions ----------------
  `WLPC_ASSERT(a_button_color, m_axis_tvalid && (m_axis_tuser == RGN_BUTTON) |-> (m_axis_tdata == COL_MINIMIZE) || (m_axis_tdata == COL_MAXIMIZE) || (m_axis_tdata == COL_CLOSE), "button region with a non-button color")
  `WLPC_ASSERT(a_title_color, m_axis_tvalid && (m_axis_tuser == RGN_TITLE) |-> (m_axis_tdata == COL_TITLE_FOCUS) || (m_axis_tdata == COL_TITLE_IDLE), "title region with a non-title color")
  `WLPC_ASSERT(a_stage3_held, v3 && !rdy4 |=> v3 && $stable(s3_sum[0]) && $stable(s3_mode), "stage 3 lost a held request")
  `WLPC_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_axis_tvalid, "output valid right after reset")

endmodule

// ----- test/window_layer_pixel_compositor_top_test.sv -----
`timescale 1ns / 1ps

module window_layer_pixel_compositor_top_test;
  import wlpc_pkg::*;

  localparam int CB = 12;
  localparam int TDATA_W = ((2 * CB + 64 + 7) / 8) * 8;

  localparam logic [3:0] F_DECO     = 4'(1 << FLAG_DECORATED);
  localparam logic [3:0] F_FOCUS    = 4'(1 << FLAG_FOCUSED);
  localparam logic [3:0] F_MIN      = 4'(1 << FLAG_MINIMIZED);
  localparam logic [3:0] F_NOSHADOW = 4'(1 << FLAG_NO_SHADOW);

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [31:0]        m_axis_tdata;
  logic [2:0]         m_axis_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [CB-1:0]      cfg_data;

  window_layer_pixel_compositor_top #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Expected composited pixels, computed from a private copy of the window registers.
  class composite_book;
    typedef struct packed {
      logic [31:0] pixel;
      region_t     region;
    } result_t;

    logic [CB-1:0] left_reg, top_reg, width_reg, height_reg;
    logic [3:0]    flags_reg;
    result_t       expected[$];
    int            mismatches;
    int            strays;

    function new();
      left_reg   = '0;
      top_reg    = '0;
      width_reg  = '0;
      height_reg = '0;
      flags_reg  = F_DECO;
      mismatches = 0;
      strays     = 0;
    endfunction

    function void apply_reg(logic [2:0] idx, logic [CB-1:0] data);
      case (idx)
        CFG_WIN_X:      left_reg = data;
        CFG_WIN_Y:      top_reg = data;
        CFG_WIN_WIDTH:  width_reg = data;
        CFG_WIN_HEIGHT: height_reg = data;
        CFG_FLAGS:      flags_reg = data[3:0];
        default: ;
      endcase
    endfunction

    function bit span(int p, int lo, int len);
      return p >= lo && p < lo + len;
    endfunction

    // fg over bg, channels divided by 255 and truncated
    function logic [31:0] blend(logic [31:0] bg, logic [31:0] fg);
      int a;
      int c;
      logic [31:0] res;
      a = int'(fg[31:24]);
      if (a == 255) return fg;
      if (a == 0) return bg;
      res = 32'hFF00_0000;
      for (int s = 0; s < 24; s += 8) begin
        c = (int'(fg[s +: 8]) * a + int'(bg[s +: 8]) * (255 - a)) / 255;
        res[s +: 8] = c[7:0];
      end
      return res;
    endfunction

    function result_t composite(logic [CB-1:0] px_b, logic [CB-1:0] py_b,
                                logic [31:0] under, logic [31:0] win);
      result_t r;
      int px, py, wx, wy, ww, wh, bx, by, dx, dy, ring_d;
      bit hit;
      logic [7:0] shade;
      px = int'(px_b);
      py = int'(py_b);
      wx = int'($signed(left_reg));
      wy = int'($signed(top_reg));
      ww = int'(width_reg);
      wh = int'(height_reg);
      r.pixel = under;
      r.region = RGN_PASS;
      hit = 1'b0;
      if (flags_reg[FLAG_MINIMIZED]) begin
        // minimized: pixel beneath passes through
      end else if (span(px, wx, ww) && span(py, wy, wh)) begin
        r.pixel = blend(under, win);
        r.region = RGN_CONTENT;
      end else begin
        if (flags_reg[FLAG_DECORATED]) begin
          by = wy - BTN_Y_OFF;
          bx = wx + ww - BTN_X_OFF;
          if (span(py, by, BTN_SIZE)) begin
            hit = 1'b1;
            if (span(px, bx, BTN_SIZE)) r.pixel = COL_MINIMIZE;
            else if (span(px, bx + BTN_STEP, BTN_SIZE)) r.pixel = COL_MAXIMIZE;
            else if (span(px, bx + 2 * BTN_STEP, BTN_SIZE)) r.pixel = COL_CLOSE;
            else hit = 1'b0;
            if (hit) r.region = RGN_BUTTON;
          end
          if (!hit && span(px, wx, ww) && span(py, wy - TITLE_H, TITLE_H)) begin
            r.pixel = flags_reg[FLAG_FOCUSED] ? COL_TITLE_FOCUS : COL_TITLE_IDLE;
            r.region = RGN_TITLE;
            hit = 1'b1;
          end
        end
        if (!hit && !flags_reg[FLAG_NO_SHADOW] &&
            span(px, wx - SHADOW_W, ww + 2 * SHADOW_W) &&
            span(py, wy - SHADOW_W, wh + 2 * SHADOW_W)) begin
          dx = 0;
          dy = 0;
          if (px < wx) dx = wx - px;
          else if (px >= wx + ww) dx = px - (wx + ww) + 1;
          if (py < wy) dy = wy - py;
          else if (py >= wy + wh) dy = py - (wy + wh) + 1;
          ring_d = dx > dy ? dx : dy;
          shade = 8'((SHADOW_W - ring_d) * SHADOW_STEP);
          r.pixel = blend(under, {shade, 24'h0});
          r.region = RGN_SHADOW;
        end
      end
      return r;
    endfunction

    function void note_pixel(logic [CB-1:0] px, logic [CB-1:0] py,
                             logic [31:0] under, logic [31:0] win);
      expected.push_back(composite(px, py, under, win));
    endfunction

    function void check_pixel(logic [31:0] pix, logic [2:0] rgn);
      result_t e;
      if (expected.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("unexpected pixel %h region %0d", pix, rgn);
        return;
      end
      e = expected.pop_front();
      if (pix !== e.pixel || rgn !== e.region) begin
        mismatches++;
        if (mismatches + strays <= 10)
          $display("pixel mismatch: expected %h region %0d, got %h region %0d",
                   e.pixel, e.region, pix, rgn);
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function bit clean();
      if (expected.size() != 0)
        $display("%0d pixels never came out", expected.size());
      return mismatches == 0 && strays == 0 && expected.size() == 0;
    endfunction
  endclass

  composite_book book = new();

  // window as the stimulus sees it, decoded to signed integers
  int win_left, win_top, win_w, win_h;
  bit steady_send, steady_take;
  int hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_argb();
    logic [31:0] p;
    p = $urandom;
    case ($urandom_range(0, 5))
      0: p[31:24] = 8'h00;
      1: p[31:24] = 8'hFF;
      2: p[31:24] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: ;
    endcase
    return p;
  endfunction

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int stall;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall = pick_gap(steady_take);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_pixel(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_pixel(input logic [CB-1:0] px, input logic [CB-1:0] py,
                            input logic [31:0] under, input logic [31:0] win);
    int gap;
    gap = pick_gap(steady_send);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({win, under, py, px});
    do @(posedge clk); while (!s_axis_tready);
    book.note_pixel(px, py, under, win);
  endtask

  // drops the request line, then waits for every pending pixel
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CB-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    book.apply_reg(idx, data);
  endtask

  task automatic configure(input int wx, input int wy, input int ww, input int wh,
                           input logic [3:0] flags);
    wait_drained();
    write_reg(CFG_WIN_X, CB'(wx));
    write_reg(CFG_WIN_Y, CB'(wy));
    write_reg(CFG_WIN_WIDTH, CB'(ww));
    write_reg(CFG_WIN_HEIGHT, CB'(wh));
    write_reg(CFG_FLAGS, {(CB - 4)'($urandom), flags});
    // unused index, must change nothing
    if ($urandom_range(0, 2) == 0)
      write_reg(3'(CFG_FLAGS) + 3'($urandom_range(1, 3)), CB'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    // derived window edges update in the cycle after a write
    repeat (3) @(posedge clk);
    win_left = wx;
    win_top  = wy;
    win_w    = ww;
    win_h    = wh;
  endtask

  task automatic random_pixel();
    int px, py, k;
    k = $urandom_range(0, 99);
    if (k < 35) begin
      px = win_left - 10 + int'($urandom_range(0, win_w + 20));
      py = win_top - 30 + int'($urandom_range(0, win_h + 40));
    end else if (k < 55) begin
      // button strip
      px = win_left + win_w - 60 + int'($urandom_range(0, 64));
      py = win_top - 26 + int'($urandom_range(0, 28));
    end else if (k < 65) begin
      px = win_left - 10 + int'($urandom_range(0, win_w + 20));
      py = win_top - 26 + int'($urandom_range(0, 28));
    end else if (k < 85) begin
      // shadow ring, top/bottom or left/right band
      if ($urandom_range(0, 1)) begin
        px = win_left - 9 + int'($urandom_range(0, win_w + 18));
        py = ($urandom_range(0, 1) ? win_top - 9 : win_top + win_h) +
             int'($urandom_range(0, 9));
      end else begin
        py = win_top - 9 + int'($urandom_range(0, win_h + 18));
        px = ($urandom_range(0, 1) ? win_left - 9 : win_left + win_w) +
             int'($urandom_range(0, 9));
      end
    end else begin
      px = $urandom_range(0, 4095);
      py = $urandom_range(0, 4095);
    end
    send_pixel(CB'(px), CB'(py), random_argb(), random_argb());
  endtask

  task automatic run_phase(input int wx, input int wy, input int ww, input int wh,
                           input logic [3:0] flags, input bit quiet, input bit squeeze);
    configure(wx, wy, ww, wh, flags);
    steady_send = quiet || squeeze;
    steady_take = quiet;
    // receiver holds off long enough for the pipeline to back up into the input
    if (squeeze) hold_left = 300;
    for (int i = 0; i < 100; i++) begin
      if (squeeze && i == 50) wait_drained();
      random_pixel();
    end
    steady_send = 1'b0;
    steady_take = 1'b0;
  endtask

  initial begin
    int rx, ry, rw, rh;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    steady_send   = 1'b0;
    steady_take   = 1'b0;
    hold_left     = 0;
    win_left      = 0;
    win_top       = 0;
    win_w         = 0;
    win_h         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // buttons at columns 246, 264, 282 on rows 80..95; title rows 76..99
    configure(100, 100, 200, 50, F_DECO | F_FOCUS);
    send_pixel(100, 100, 32'h1122_3344, 32'hFF12_3456);
    send_pixel(299, 149, 32'h1122_3344, 32'h00AB_CDEF);
    send_pixel(150, 120, 32'h80FF_0000, 32'h8000_FF80);
    send_pixel(200, 120, 32'hFFFF_FFFF, 32'h0100_0000);
    send_pixel(201, 120, 32'h0000_0000, 32'hFEFF_FFFF);
    send_pixel(250, 85, 32'h1234_5678, 32'hDEAD_BEEF);
    send_pixel(270, 85, 32'h1234_5678, 32'hDEAD_BEEF);
    send_pixel(290, 85, 32'h1234_5678, 32'hDEAD_BEEF);
    send_pixel(262, 85, 32'h1234_5678, 32'hDEAD_BEEF);
    send_pixel(100, 76, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(299, 99, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(150, 96, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(99, 120, 32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(92, 120, 32'hFFFF_FFFF, 32'h0000_0000);
    send_pixel(305, 155, 32'hFF80_40C0, 32'h0000_0000);
    send_pixel(92, 92, 32'hFF80_40C0, 32'h0000_0000);
    send_pixel(91, 120, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_pixel(301, 77, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_pixel(0, 0, 32'h0000_0000, 32'h0000_0000);
    send_pixel(4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    run_phase(-10, -5, 100, 40, F_DECO, 1'b1, 1'b0);
    run_phase(2047, 2047, 4095, 4095, F_DECO | F_FOCUS, 1'b0, 1'b0);
    run_phase(-2048, -2048, 4095, 4095, 4'b0000, 1'b0, 1'b0);
    run_phase(300, 200, 0, 30, F_DECO, 1'b0, 1'b1);
    run_phase(300, 200, 60, 0, F_DECO | F_FOCUS | F_NOSHADOW, 1'b0, 1'b0);
    run_phase(50, 60, 30, 20, F_MIN, 1'b0, 1'b0);
    run_phase(100, 100, 5, 5, F_DECO | F_FOCUS | F_MIN | F_NOSHADOW, 1'b0, 1'b0);
    run_phase(0, 0, 0, 0, F_FOCUS, 1'b0, 1'b0);
    run_phase(1000, 20, 60, 300, F_DECO | F_NOSHADOW, 1'b0, 1'b0);
    for (int p = 0; p < 4; p++) begin
      rx = int'($signed(CB'($urandom)));
      ry = int'($signed(CB'($urandom)));
      rw = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      rh = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 200);
      run_phase(rx, ry, rw, rh, 4'($urandom), 1'b0, 1'b0);
    end

    wait_drained();
    repeat (12) @(posedge clk);
    if (book.clean()) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/wlpc_pkg.sv
rtl/window_layer_pixel_compositor_top.sv
test/window_layer_pixel_compositor_top_test.sv
